// File: hdl/cpot_pkg.sv
// ---------------------------------------------------------------------------
// cpot_pkg: shared constants for the collider pair overlap test
// Shape codes and the default coordinate width.
// ---------------------------------------------------------------------------
package cpot_pkg;

	localparam int unsigned COORD_BITS_DEF = 24;

	localparam logic [1:0] SHAPE_UNKNOWN = 2'd0;
	localparam logic [1:0] SHAPE_BOX     = 2'd1;
	localparam logic [1:0] SHAPE_CIRCLE  = 2'd2;

endpackage

// File: hdl/collider_pair_overlap_test_unit.sv
// An accepted input beat passes through the stage 1 to stage 4 registers to its result beat.
// One pair per cycle while out_stall is low; each of the four stages advances
// whenever it is empty or the stage after it moves, so bubbles collapse.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// collider_pair_overlap_test_unit: 2D box/circle pair overlap test
// Four-stage pipeline: role setup, clamp distance, squares, compare.
// ---------------------------------------------------------------------------
module collider_pair_overlap_test_unit #(
	parameter int unsigned COORD_BITS = cpot_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   a_shape,
	input  logic signed [COORD_BITS-1:0] a_center_x,
	input  logic signed [COORD_BITS-1:0] a_center_y,
	input  logic [COORD_BITS-2:0]        a_size_x,
	input  logic [COORD_BITS-2:0]        a_size_y,
	input  logic [1:0]                   b_shape,
	input  logic signed [COORD_BITS-1:0] b_center_x,
	input  logic signed [COORD_BITS-1:0] b_center_y,
	input  logic [COORD_BITS-2:0]        b_size_x,
	input  logic [COORD_BITS-2:0]        b_size_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit
);

	localparam int unsigned W = COORD_BITS;

	logic en1, en2, en3, en4;

	logic                v_s1, known_s1;
	logic signed [W+1:0] lo_x_s1, hi_x_s1, lo_y_s1, hi_y_s1;
	logic signed [W-1:0] cx_s1, cy_s1;
	logic [W-1:0]        rad_s1;

	logic         v_s2, known_s2;
	logic [W:0]   mag_x_s2, mag_y_s2;
	logic [W-1:0] rad_s2;

	logic             v_s3, known_s3;
	logic [2*W+1:0]   sq_x_s3, sq_y_s3;
	logic [2*W-1:0]   sq_r_s3;

	logic v_s4, hit_s4;

	// a stage moves when it is empty or its successor moves
	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_stall  = !en1;
	assign out_valid = v_s4;
	assign hit       = hit_s4;

	cpot_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en1),
		.v_in       (in_valid),
		.a_shape    (a_shape),
		.a_center_x (a_center_x),
		.a_center_y (a_center_y),
		.a_size_x   (a_size_x),
		.a_size_y   (a_size_y),
		.b_shape    (b_shape),
		.b_center_x (b_center_x),
		.b_center_y (b_center_y),
		.b_size_x   (b_size_x),
		.b_size_y   (b_size_y),
		.v_s1       (v_s1),
		.known_s1   (known_s1),
		.lo_x_s1    (lo_x_s1),
		.hi_x_s1    (hi_x_s1),
		.lo_y_s1    (lo_y_s1),
		.hi_y_s1    (hi_y_s1),
		.cx_s1      (cx_s1),
		.cy_s1      (cy_s1),
		.rad_s1     (rad_s1)
	);

	cpot_clamp #(.COORD_BITS(COORD_BITS)) u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.v_in     (v_s1),
		.known_in (known_s1),
		.lo_x     (lo_x_s1),
		.hi_x     (hi_x_s1),
		.lo_y     (lo_y_s1),
		.hi_y     (hi_y_s1),
		.cx       (cx_s1),
		.cy       (cy_s1),
		.rad_in   (rad_s1),
		.v_s2     (v_s2),
		.known_s2 (known_s2),
		.mag_x_s2 (mag_x_s2),
		.mag_y_s2 (mag_y_s2),
		.rad_s2   (rad_s2)
	);

	cpot_square #(.COORD_BITS(COORD_BITS)) u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.v_in     (v_s2),
		.known_in (known_s2),
		.mag_x    (mag_x_s2),
		.mag_y    (mag_y_s2),
		.rad_in   (rad_s2),
		.v_s3     (v_s3),
		.known_s3 (known_s3),
		.sq_x_s3  (sq_x_s3),
		.sq_y_s3  (sq_y_s3),
		.sq_r_s3  (sq_r_s3)
	);

	cpot_compare #(.COORD_BITS(COORD_BITS)) u_compare (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en4),
		.v_in     (v_s3),
		.known_in (known_s3),
		.sq_x     (sq_x_s3),
		.sq_y     (sq_y_s3),
		.sq_r     (sq_r_s3),
		.v_s4     (v_s4),
		.hit_s4   (hit_s4)
	);

endmodule

// File: hdl/cpot_setup.sv
// ---------------------------------------------------------------------------
// cpot_setup: stage 1, role selection and box bounds
// Every pair becomes one box and one circle center with a radius, then the
// box edges are formed. Box/box uses the Minkowski-expanded box with radius
// zero. Circle/circle uses a zero-size box with the summed radii; other codes clear known.
// ---------------------------------------------------------------------------
module cpot_setup #(
	parameter int unsigned COORD_BITS = cpot_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         v_in,
	input  logic [1:0]                   a_shape,
	input  logic signed [COORD_BITS-1:0] a_center_x,
	input  logic signed [COORD_BITS-1:0] a_center_y,
	input  logic [COORD_BITS-2:0]        a_size_x,
	input  logic [COORD_BITS-2:0]        a_size_y,
	input  logic [1:0]                   b_shape,
	input  logic signed [COORD_BITS-1:0] b_center_x,
	input  logic signed [COORD_BITS-1:0] b_center_y,
	input  logic [COORD_BITS-2:0]        b_size_x,
	input  logic [COORD_BITS-2:0]        b_size_y,
	output logic                         v_s1,
	output logic                         known_s1,
	output logic signed [COORD_BITS+1:0] lo_x_s1,
	output logic signed [COORD_BITS+1:0] hi_x_s1,
	output logic signed [COORD_BITS+1:0] lo_y_s1,
	output logic signed [COORD_BITS+1:0] hi_y_s1,
	output logic signed [COORD_BITS-1:0] cx_s1,
	output logic signed [COORD_BITS-1:0] cy_s1,
	output logic [COORD_BITS-1:0]        rad_s1
);

	localparam int unsigned W  = COORD_BITS;
	localparam int unsigned EW = COORD_BITS + 2;

	logic signed [W-1:0] box_x, box_y, cir_x, cir_y;
	logic [W-1:0]        half_x, half_y, rad;
	logic                known;
	logic signed [EW-1:0] box_x_e, box_y_e;

	always_comb begin
		known  = 1'b1;
		box_x  = a_center_x;
		box_y  = a_center_y;
		cir_x  = b_center_x;
		cir_y  = b_center_y;
		half_x = '0;
		half_y = '0;
		rad    = '0;
		case ({a_shape, b_shape})
			{cpot_pkg::SHAPE_BOX, cpot_pkg::SHAPE_BOX}: begin
				half_x = W'(a_size_x) + W'(b_size_x);
				half_y = W'(a_size_y) + W'(b_size_y);
			end
			{cpot_pkg::SHAPE_CIRCLE, cpot_pkg::SHAPE_CIRCLE}: begin
				rad = W'(a_size_x) + W'(b_size_x);
			end
			{cpot_pkg::SHAPE_BOX, cpot_pkg::SHAPE_CIRCLE}: begin
				half_x = W'(a_size_x);
				half_y = W'(a_size_y);
				rad    = W'(b_size_x);
			end
			{cpot_pkg::SHAPE_CIRCLE, cpot_pkg::SHAPE_BOX}: begin
				box_x  = b_center_x;
				box_y  = b_center_y;
				cir_x  = a_center_x;
				cir_y  = a_center_y;
				half_x = W'(b_size_x);
				half_y = W'(b_size_y);
				rad    = W'(a_size_x);
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign box_x_e = EW'(box_x);
	assign box_y_e = EW'(box_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			known_s1 <= known;
			lo_x_s1  <= box_x_e - $signed(EW'(half_x));
			hi_x_s1  <= box_x_e + $signed(EW'(half_x));
			lo_y_s1  <= box_y_e - $signed(EW'(half_y));
			hi_y_s1  <= box_y_e + $signed(EW'(half_y));
			cx_s1    <= cir_x;
			cy_s1    <= cir_y;
			rad_s1   <= rad;
		end
	end

endmodule

// File: hdl/cpot_clamp.sv
// ---------------------------------------------------------------------------
// cpot_clamp: stage 2, distance from circle center to the box
// Per axis the distance is zero inside the box, else the gap to the
// nearer edge, kept as an unsigned magnitude.
// ---------------------------------------------------------------------------
module cpot_clamp #(
	parameter int unsigned COORD_BITS = cpot_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         v_in,
	input  logic                         known_in,
	input  logic signed [COORD_BITS+1:0] lo_x,
	input  logic signed [COORD_BITS+1:0] hi_x,
	input  logic signed [COORD_BITS+1:0] lo_y,
	input  logic signed [COORD_BITS+1:0] hi_y,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic [COORD_BITS-1:0]        rad_in,
	output logic                         v_s2,
	output logic                         known_s2,
	output logic [COORD_BITS:0]          mag_x_s2,
	output logic [COORD_BITS:0]          mag_y_s2,
	output logic [COORD_BITS-1:0]        rad_s2
);

	localparam int unsigned EW = COORD_BITS + 2;
	localparam int unsigned MW = COORD_BITS + 1;

	logic signed [EW-1:0] cx_e, cy_e, gap_x, gap_y;

	assign cx_e = EW'(cx);
	assign cy_e = EW'(cy);

	always_comb begin
		if (cx_e < lo_x) begin
			gap_x = lo_x - cx_e;
		end else if (cx_e > hi_x) begin
			gap_x = cx_e - hi_x;
		end else begin
			gap_x = '0;
		end
		if (cy_e < lo_y) begin
			gap_y = lo_y - cy_e;
		end else if (cy_e > hi_y) begin
			gap_y = cy_e - hi_y;
		end else begin
			gap_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			known_s2 <= known_in;
			mag_x_s2 <= gap_x[MW-1:0];
			mag_y_s2 <= gap_y[MW-1:0];
			rad_s2   <= rad_in;
		end
	end

endmodule

// File: hdl/cpot_square.sv
// ---------------------------------------------------------------------------
// cpot_square: stage 3, squares
// Squares of both axis distances and of the radius, full width.
// ---------------------------------------------------------------------------
module cpot_square #(
	parameter int unsigned COORD_BITS = cpot_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  logic                        known_in,
	input  logic [COORD_BITS:0]         mag_x,
	input  logic [COORD_BITS:0]         mag_y,
	input  logic [COORD_BITS-1:0]       rad_in,
	output logic                        v_s3,
	output logic                        known_s3,
	output logic [2*COORD_BITS+1:0]     sq_x_s3,
	output logic [2*COORD_BITS+1:0]     sq_y_s3,
	output logic [2*COORD_BITS-1:0]     sq_r_s3
);

	localparam int unsigned SW = 2 * COORD_BITS + 2;
	localparam int unsigned RW = 2 * COORD_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			known_s3 <= known_in;
			sq_x_s3  <= SW'(mag_x) * SW'(mag_x);
			sq_y_s3  <= SW'(mag_y) * SW'(mag_y);
			sq_r_s3  <= RW'(rad_in) * RW'(rad_in);
		end
	end

endmodule

// File: hdl/cpot_compare.sv
// ---------------------------------------------------------------------------
// cpot_compare: stage 4, distance against radius
// Sums the squared distances and compares with the squared radius; this
// register is the output register.
// ---------------------------------------------------------------------------
module cpot_compare #(
	parameter int unsigned COORD_BITS = cpot_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    v_in,
	input  logic                    known_in,
	input  logic [2*COORD_BITS+1:0] sq_x,
	input  logic [2*COORD_BITS+1:0] sq_y,
	input  logic [2*COORD_BITS-1:0] sq_r,
	output logic                    v_s4,
	output logic                    hit_s4
);

	localparam int unsigned DW = 2 * COORD_BITS + 3;

	logic [DW-1:0] dist_sq;

	assign dist_sq = DW'(sq_x) + DW'(sq_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= known_in && (dist_sq <= DW'(sq_r));
		end
	end

endmodule

// File: tb/collider_pair_overlap_test_unit_tb.sv
// ---------------------------------------------------------------------------
// collider_pair_overlap_test_unit_tb: self-checking bench for the pair test
// Streams box/circle collider pairs through the unit under random idling on
// both sides. Each accepted pair is scored by an exact integer model, and
// every result beat is checked in order against the oldest expected hit.
// ---------------------------------------------------------------------------
module collider_pair_overlap_test_unit_tb;

	localparam int CB = cpot_pkg::COORD_BITS_DEF;
	localparam logic [1:0] SHAPE_RESERVED = 2'd3;
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-2:0] SMAX = '1;
	localparam int unsigned BATCH_A = 260;
	localparam int unsigned BATCH_B = 270;
	localparam int unsigned HOLD_AT = 120;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [1:0]           shape;
		logic signed [CB-1:0] cx;
		logic signed [CB-1:0] cy;
		logic [CB-2:0]        sx;
		logic [CB-2:0]        sy;
	} collider_t;

	typedef struct packed {
		collider_t a;
		collider_t b;
	} pair_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	pair_t       tx_item = '0;

	pair_t       pairs_to_send[$];
	logic        hits_due[$];
	int unsigned n_accepted;
	int unsigned n_errors = 0;
	int unsigned tx_gap, rx_gap, hold_left;
	logic        hold_done;
	logic        no_idle;
	logic        due_hit;
	int unsigned cycle_cnt;

	collider_pair_overlap_test_unit #(
		.COORD_BITS(CB)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.a_shape   (tx_item.a.shape),
		.a_center_x(tx_item.a.cx),
		.a_center_y(tx_item.a.cy),
		.a_size_x  (tx_item.a.sx),
		.a_size_y  (tx_item.a.sy),
		.b_shape   (tx_item.b.shape),
		.b_center_x(tx_item.b.cx),
		.b_center_y(tx_item.b.cy),
		.b_size_x  (tx_item.b.sx),
		.b_size_y  (tx_item.b.sy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit)
	);

	always #5 clk = ~clk;

	// exact integer scoring; squares stay well inside 64 bits at 24-bit coords
	function automatic logic within_radius(longint dx, longint dy, longint r);
		return dx * dx + dy * dy <= r * r;
	endfunction

	function automatic logic box_touches_circle(collider_t box, collider_t circ);
		longint bx, by, hx, hy, cx, cy, px, py;
		bx = $signed(box.cx);
		by = $signed(box.cy);
		hx = box.sx;
		hy = box.sy;
		cx = $signed(circ.cx);
		cy = $signed(circ.cy);
		px = (cx < bx - hx) ? bx - hx : (cx > bx + hx) ? bx + hx : cx;
		py = (cy < by - hy) ? by - hy : (cy > by + hy) ? by + hy : cy;
		return within_radius(cx - px, cy - py, longint'(circ.sx));
	endfunction

	function automatic logic predict_hit(pair_t p);
		longint ax, ay, ahx, ahy, bx, by, bhx, bhy;
		ax = $signed(p.a.cx);
		ay = $signed(p.a.cy);
		ahx = p.a.sx;
		ahy = p.a.sy;
		bx = $signed(p.b.cx);
		by = $signed(p.b.cy);
		bhx = p.b.sx;
		bhy = p.b.sy;
		if (p.a.shape == cpot_pkg::SHAPE_BOX && p.b.shape == cpot_pkg::SHAPE_BOX)
			return (ax - ahx <= bx + bhx) && (ax + ahx >= bx - bhx) &&
				(ay - ahy <= by + bhy) && (ay + ahy >= by - bhy);
		if (p.a.shape == cpot_pkg::SHAPE_CIRCLE && p.b.shape == cpot_pkg::SHAPE_CIRCLE)
			return within_radius(ax - bx, ay - by, ahx + bhx);
		if (p.a.shape == cpot_pkg::SHAPE_BOX && p.b.shape == cpot_pkg::SHAPE_CIRCLE)
			return box_touches_circle(p.a, p.b);
		if (p.a.shape == cpot_pkg::SHAPE_CIRCLE && p.b.shape == cpot_pkg::SHAPE_BOX)
			return box_touches_circle(p.b, p.a);
		return 1'b0;
	endfunction

	function automatic collider_t mk(logic [1:0] shape, logic signed [CB-1:0] cx,
		logic signed [CB-1:0] cy, logic [CB-2:0] sx, logic [CB-2:0] sy);
		collider_t c;
		c.shape = shape;
		c.cx = cx;
		c.cy = cy;
		c.sx = sx;
		c.sy = sy;
		return c;
	endfunction

	task automatic add_pair(collider_t a, collider_t b);
		pair_t p;
		p.a = a;
		p.b = b;
		pairs_to_send.push_back(p);
	endtask

	// signed offset in [-2^k, 2^k)
	function automatic logic signed [CB-1:0] rand_offset(int unsigned k);
		return CB'($urandom_range(0, (32'd1 << (k + 1)) - 1)) - CB'(32'd1 << k);
	endfunction

	function automatic collider_t rand_collider(int unsigned k, logic signed [CB-1:0] x0,
		logic signed [CB-1:0] y0);
		collider_t c;
		int unsigned r;
		r = $urandom_range(0, 19);
		c.shape = (r < 9) ? cpot_pkg::SHAPE_BOX : (r < 18) ? cpot_pkg::SHAPE_CIRCLE :
			(r == 18) ? cpot_pkg::SHAPE_UNKNOWN : SHAPE_RESERVED;
		c.cx = x0 + rand_offset(k);
		c.cy = y0 + rand_offset(k);
		c.sx = (CB-1)'($urandom_range(0, (32'd1 << k) - 1));
		c.sy = (CB-1)'($urandom_range(0, (32'd1 << k) - 1));
		return c;
	endfunction

	// second collider lands near the first at the same scale, so hits and misses mix
	function automatic pair_t rand_pair();
		pair_t p;
		int unsigned k;
		k = $urandom_range(2, CB - 1);
		p.a = rand_collider(k, '0, '0);
		p.b = rand_collider(k, p.a.cx, p.a.cy);
		return p;
	endfunction

	function automatic int unsigned pick_gap(logic calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	task automatic note_mismatch(string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic wait_drained();
		while (pairs_to_send.size() != 0 || in_valid || hits_due.size() != 0)
			@(posedge clk);
	endtask

	// input side: hold the beat while stalled, otherwise idle or send the next pair
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_item <= '0;
			tx_gap <= 0;
			n_accepted <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				hits_due.push_back(predict_hit(tx_item));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pairs_to_send.size() != 0) begin
					tx_item <= pairs_to_send.pop_front();
					in_valid <= 1'b1;
					tx_gap <= pick_gap(no_idle);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off so the pipe fills and backs up into the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output side: score each result beat, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (hits_due.size() == 0) begin
					note_mismatch($sformatf("result beat with none pending, hit=%b", hit));
				end else begin
					due_hit = hits_due.pop_front();
					if (hit !== due_hit)
						note_mismatch($sformatf("hit expected %b actual %b", due_hit, hit));
				end
			end
			out_stall <= (rx_gap != 0) || (hold_left != 0);
			rx_gap <= (rx_gap != 0) ? rx_gap - 1 : pick_gap(no_idle);
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL collider_pair_overlap_test_unit");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;

		// box/box: overlap, edge touch, one lsb apart, apart on y only
		add_pair(mk(cpot_pkg::SHAPE_BOX, 0, 0, 256, 256),
			mk(cpot_pkg::SHAPE_BOX, 256, 0, 256, 256));
		add_pair(mk(cpot_pkg::SHAPE_BOX, 0, 0, 256, 256),
			mk(cpot_pkg::SHAPE_BOX, 512, 0, 256, 256));
		add_pair(mk(cpot_pkg::SHAPE_BOX, 0, 0, 256, 256),
			mk(cpot_pkg::SHAPE_BOX, 513, 0, 256, 256));
		add_pair(mk(cpot_pkg::SHAPE_BOX, 0, 0, 256, 256),
			mk(cpot_pkg::SHAPE_BOX, 0, 1000, 256, 256));
		// circle/circle: 3-4-5 touch, then one lsb short
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, 0, 0, 200, 0),
			mk(cpot_pkg::SHAPE_CIRCLE, 300, 400, 300, 0));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, 0, 0, 200, 0),
			mk(cpot_pkg::SHAPE_CIRCLE, 300, 400, 299, 0));
		// box/circle both orders: center inside, corner touch, corner miss
		add_pair(mk(cpot_pkg::SHAPE_BOX, 0, 0, 512, 512),
			mk(cpot_pkg::SHAPE_CIRCLE, 100, -100, 1, 7));
		add_pair(mk(cpot_pkg::SHAPE_BOX, 0, 0, 300, 400),
			mk(cpot_pkg::SHAPE_CIRCLE, 600, 800, 500, 0));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, -600, -800, 499, 0),
			mk(cpot_pkg::SHAPE_BOX, 0, 0, 300, 400));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, -600, -800, 500, 0),
			mk(cpot_pkg::SHAPE_BOX, 0, 0, 300, 400));
		// unknown or reserved shape codes never hit, even on identical geometry
		add_pair(mk(cpot_pkg::SHAPE_UNKNOWN, 0, 0, 256, 256),
			mk(cpot_pkg::SHAPE_BOX, 0, 0, 256, 256));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, 0, 0, 256, 256),
			mk(SHAPE_RESERVED, 0, 0, 256, 256));
		add_pair(mk(SHAPE_RESERVED, 0, 0, 9, 9), mk(cpot_pkg::SHAPE_UNKNOWN, 0, 0, 9, 9));
		// circle half height is ignored
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, 0, 0, 10, SMAX),
			mk(cpot_pkg::SHAPE_CIRCLE, 100, 0, 10, 0));
		// extreme coordinates and sizes
		add_pair(mk(cpot_pkg::SHAPE_BOX, CMIN, CMIN, SMAX, SMAX),
			mk(cpot_pkg::SHAPE_BOX, CMAX, CMAX, SMAX, SMAX));
		add_pair(mk(cpot_pkg::SHAPE_BOX, CMIN, CMIN, SMAX, SMAX),
			mk(cpot_pkg::SHAPE_BOX, CMAX - 1, CMAX, SMAX, SMAX));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, CMIN, CMIN, SMAX, 0),
			mk(cpot_pkg::SHAPE_CIRCLE, CMIN, CMAX, SMAX, 0));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, CMIN, CMIN, SMAX, 0),
			mk(cpot_pkg::SHAPE_CIRCLE, CMIN, CMAX - 1, SMAX, 0));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, CMAX, CMAX, SMAX, SMAX),
			mk(cpot_pkg::SHAPE_CIRCLE, CMIN, CMIN, SMAX, SMAX));
		add_pair(mk(cpot_pkg::SHAPE_BOX, CMAX, CMIN, SMAX, 0),
			mk(cpot_pkg::SHAPE_CIRCLE, CMIN, CMAX, SMAX, 0));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, CMAX, CMAX, SMAX, 0),
			mk(cpot_pkg::SHAPE_BOX, CMIN, CMIN, SMAX, SMAX));
		// zero sizes: coincident points hit, separated points miss
		add_pair(mk(cpot_pkg::SHAPE_BOX, 77, -77, 0, 0),
			mk(cpot_pkg::SHAPE_BOX, 77, -77, 0, 0));
		add_pair(mk(cpot_pkg::SHAPE_CIRCLE, -5, 5, 0, 0),
			mk(cpot_pkg::SHAPE_CIRCLE, -5, 5, 0, 0));
		add_pair(mk(cpot_pkg::SHAPE_BOX, 0, 0, 0, 0),
			mk(cpot_pkg::SHAPE_CIRCLE, 1, 0, 0, 0));

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait_drained();
		repeat (BATCH_A) pairs_to_send.push_back(rand_pair());
		// sender sits idle until everything in flight has come back
		wait_drained();
		repeat (BATCH_B) pairs_to_send.push_back(rand_pair());
		while (n_accepted < 400) @(posedge clk);
		no_idle <= 1'b1;
		while (n_accepted < 470) @(posedge clk);
		no_idle <= 1'b0;
		wait_drained();
		repeat (12) @(posedge clk);

		if (n_errors == 0)
			$display("PASS collider_pair_overlap_test_unit");
		else
			$display("FAIL collider_pair_overlap_test_unit");
		$finish;
	end

endmodule

// File: filelist.f
hdl/cpot_pkg.sv
hdl/cpot_setup.sv
hdl/cpot_clamp.sv
hdl/cpot_square.sv
hdl/cpot_compare.sv
hdl/collider_pair_overlap_test_unit.sv
tb/collider_pair_overlap_test_unit_tb.sv
